/* hdl/hxl_pkg.sv */
// Shared types and constants of the hex text memory loader.
package hxl_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned WordW    = 16;
  localparam int unsigned SpanW    = 17;
  localparam int unsigned KindW    = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;

  localparam logic [ByteW-1:0] CharDot    = 8'h2E;
  localparam logic [ByteW-1:0] CharEqual  = 8'h3D;
  localparam logic [ByteW-1:0] CharPcent  = 8'h25;
  localparam logic [ByteW-1:0] CharBang   = 8'h21;
  localparam logic [ByteW-1:0] CharComma  = 8'h2C;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharTab    = 8'h09;
  localparam logic [ByteW-1:0] CharLf     = 8'h0A;
  localparam logic [ByteW-1:0] CharCr     = 8'h0D;
  localparam logic [ByteW-1:0] CharStep   = 8'h73;
  localparam logic [ByteW-1:0] CharGo     = 8'h67;
  localparam logic [AddrW-1:0] DumpMask   = 16'hFFF0;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 3'd0,
    KIND_BREAK = 3'd1,
    KIND_DUMP  = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_START = 3'd4,
    KIND_END   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_LOAD  = 3'd1,
    OP_BREAK = 3'd2,
    OP_BANG  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_START = 3'd5,
    OP_END   = 3'd6
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RAM_BASE = 1'b0,
    REG_RAM_SPAN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] value;
    logic             step;
  } cmd_t;

endpackage

/* hdl/hxl_front.sv */
// Character parser that turns received text into loader commands.
module hxl_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [hxl_pkg::ByteW-1:0] in_byte_i,
  input  logic                      full_i,
  output logic                      cmd_valid_o,
  output hxl_pkg::cmd_t             cmd_o
);
  import hxl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_TOKEN = 3'b010,
    MODE_DONE  = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    TOK_DATA  = 2'd0,
    TOK_LOAD  = 2'd1,
    TOK_BREAK = 2'd2
  } tok_e;

  function automatic logic [4:0] hex_val(logic [ByteW-1:0] c);
    logic [ByteW-1:0] upper;
    upper = c & 8'hDF;
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end else if (upper >= 8'h41 && upper <= 8'h46) begin
      return {1'b1, upper[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  mode_e            mode_q, mode_d;
  tok_e             tok_q, tok_d;
  logic [1:0]       dots_q, dots_d;
  logic [WordW-1:0] accum_q, accum_d;
  logic             accept;
  logic [4:0]       hex;
  logic             is_space;

  assign accept   = push_i && !full_i;
  assign hex      = hex_val(in_byte_i);
  assign is_space = (in_byte_i == CharSpace) || (in_byte_i == CharTab) ||
                    (in_byte_i == CharLf) || (in_byte_i == CharCr);

  always_comb begin
    mode_d      = mode_q;
    tok_d       = tok_q;
    dots_d      = dots_q;
    accum_d     = accum_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = OP_WRITE;
    cmd_o.value = '0;
    cmd_o.step  = 1'b0;
    if (accept && mode_q != MODE_DONE) begin
      if (in_byte_i == CharDot) begin
        if (dots_q >= 2'd2) begin
          dots_d      = 2'd0;
          mode_d      = MODE_DONE;
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_END;
        end else begin
          dots_d = dots_q + 2'd1;
        end
      end else begin
        dots_d = 2'd0;
        unique case (mode_q)
          MODE_TOKEN: begin
            if (hex[4]) begin
              accum_d = {accum_q[WordW-5:0], hex[3:0]};
            end else begin
              cmd_valid_o = 1'b1;
              cmd_o.value = accum_q;
              unique case (tok_q)
                TOK_LOAD:  cmd_o.op = OP_LOAD;
                TOK_BREAK: cmd_o.op = OP_BREAK;
                default:   cmd_o.op = OP_WRITE;
              endcase
              accum_d = '0;
              mode_d  = MODE_IDLE;
            end
          end
          default: begin
            priority if (is_space) begin
              mode_d = MODE_IDLE;
            end else if (in_byte_i == CharBang) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_BANG;
            end else if (in_byte_i == CharStep || in_byte_i == CharGo) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_START;
              cmd_o.step  = (in_byte_i == CharStep);
              mode_d      = MODE_DONE;
            end else if (in_byte_i == CharComma) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_CLEAR;
            end else if (in_byte_i == CharEqual || in_byte_i == CharPcent) begin
              tok_d   = (in_byte_i == CharEqual) ? TOK_LOAD : TOK_BREAK;
              accum_d = '0;
              mode_d  = MODE_TOKEN;
            end else if (hex[4]) begin
              tok_d   = TOK_DATA;
              accum_d = {{(WordW-4){1'b0}}, hex[3:0]};
              mode_d  = MODE_TOKEN;
            end else begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_WRITE;
              tok_d       = TOK_DATA;
              accum_d     = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      tok_q   <= TOK_DATA;
      dots_q  <= 2'd0;
      accum_q <= '0;
    end else begin
      mode_q  <= mode_d;
      tok_q   <= tok_d;
      dots_q  <= dots_d;
      accum_q <= accum_d;
    end
  end

endmodule

/* hdl/hxl_cmd_fifo.sv */
// Two-entry command queue between the parser and the executor.
module hxl_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  hxl_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output hxl_pkg::cmd_t rdata_o
);
  import hxl_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

endmodule

/* hdl/hxl_back.sv */
// Command executor holding the load address, the marks and the result register.
module hxl_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  hxl_pkg::cmd_t                cmd_i,
  output logic                         cmd_rd_o,
  input  logic                         cfg_we_i,
  input  logic [hxl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hxl_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [hxl_pkg::KindW-1:0]    kind_o,
  output logic [hxl_pkg::AddrW-1:0]    mem_address_o,
  output logic [hxl_pkg::WordW-1:0]    word_value_o,
  output logic                         step_mode_o
);
  import hxl_pkg::*;

  logic [AddrW-1:0] base_q, base_d;
  logic [SpanW-1:0] span_q, span_d;
  logic [AddrW-1:0] load_q, load_d;
  logic [AddrW-1:0] low_q, low_d;
  logic [AddrW-1:0] high_q, high_d;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [WordW-1:0] word_q, word_d;
  logic             step_q, step_d;

  logic             fire;
  logic [AddrW-1:0] diff, next_addr;
  logic             in_win, wrap, dump_ok, do_write;
  logic [WordW-1:0] wdata;
  logic [17:0]      top_sum;

  assign empty_o       = !out_valid_q;
  assign kind_o        = kind_q;
  assign mem_address_o = addr_q;
  assign word_value_o  = word_q;
  assign step_mode_o   = step_q;

  assign fire     = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_rd_o = fire;

  assign diff      = load_q - base_q;
  assign in_win    = (load_q >= base_q) && ({1'b0, diff} < span_q);
  assign next_addr = load_q + 16'd2;
  assign wrap      = next_addr < load_q;
  assign dump_ok   = low_q < high_q;
  assign do_write  = (cmd_i.op == OP_WRITE) || (cmd_i.op == OP_BANG && !dump_ok);
  assign wdata     = (cmd_i.op == OP_BANG) ? '0 : cmd_i.value;

  always_comb begin
    base_d = base_q;
    span_d = span_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RAM_BASE: base_d = cfg_wdata_i[AddrW-1:0];
        REG_RAM_SPAN: span_d = cfg_wdata_i[SpanW-1:0];
        default:      base_d = base_q;
      endcase
    end
    top_sum = 18'(base_d) + 18'(span_d) - 18'd1;
  end

  always_comb begin
    load_d      = load_q;
    low_d       = low_q;
    high_d      = high_q;
    out_valid_d = out_valid_q && !pop_i;
    kind_d      = kind_q;
    addr_d      = addr_q;
    word_d      = word_q;
    step_d      = step_q;
    if (fire) begin
      kind_d = KIND_WRITE;
      addr_d = '0;
      word_d = '0;
      step_d = 1'b0;
      if (do_write) begin
        if (in_win) begin
          out_valid_d = 1'b1;
          addr_d      = load_q;
          word_d      = wdata;
          load_d      = next_addr;
          if (high_q < next_addr) begin
            high_d = next_addr;
          end
          if (wrap || load_q < low_q) begin
            low_d = load_q;
          end
        end
      end else begin
        unique case (cmd_i.op)
          OP_LOAD: begin
            load_d = cmd_i.value;
          end
          OP_BREAK: begin
            out_valid_d = 1'b1;
            kind_d      = KIND_BREAK;
            word_d      = cmd_i.value;
          end
          OP_BANG: begin
            out_valid_d = 1'b1;
            kind_d      = KIND_DUMP;
            addr_d      = low_q & DumpMask;
            word_d      = high_q;
          end
          OP_CLEAR: begin
            out_valid_d = 1'b1;
            kind_d      = KIND_CLEAR;
          end
          OP_START: begin
            out_valid_d = 1'b1;
            kind_d      = KIND_START;
            step_d      = cmd_i.step;
          end
          OP_END: begin
            out_valid_d = 1'b1;
            kind_d      = KIND_END;
          end
          default: begin
            load_d = load_q;
          end
        endcase
      end
    end
    if (cfg_we_i) begin
      low_d = top_sum[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    word_q <= word_d;
    step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      span_q      <= 17'h10000;
      load_q      <= '0;
      low_q       <= 16'hFFFF;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      span_q      <= span_d;
      load_q      <= load_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/hex_text_memory_loader_unit.sv */
// Top level of the hex text memory loader: parser, command queue and executor.
//
//   Channel   Handshake                   Payload
//   input     push_i / full_o             in_byte_i
//   result    pop_i / empty_o             kind_o, mem_address_o, word_value_o, step_mode_o
//   config    cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One character is taken in every cycle unless full_o is high; the parser updates its
// state in the same cycle. Its command is written into the queue, then moved into the
// result register once that register is empty or is being popped.
// Reset empties the queue and the result register and restores all loader state.
// The queue holds two commands, so a stalled result side stops input only once both fill.
module hex_text_memory_loader_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [hxl_pkg::ByteW-1:0]    in_byte_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [hxl_pkg::KindW-1:0]    kind_o,
  output logic [hxl_pkg::AddrW-1:0]    mem_address_o,
  output logic [hxl_pkg::WordW-1:0]    word_value_o,
  output logic                         step_mode_o,
  input  logic                         cfg_we_i,
  input  logic [hxl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hxl_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import hxl_pkg::*;

  logic cmd_wr, cmd_valid, cmd_rd;
  cmd_t cmd_in, cmd_out;

  hxl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_byte_i   (in_byte_i),
    .full_i      (full_o),
    .cmd_valid_o (cmd_wr),
    .cmd_o       (cmd_in)
  );

  hxl_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .rd_i    (cmd_rd),
    .valid_o (cmd_valid),
    .rdata_o (cmd_out)
  );

  hxl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_rd_o      (cmd_rd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .kind_o        (kind_o),
    .mem_address_o (mem_address_o),
    .word_value_o  (word_value_o),
    .step_mode_o   (step_mode_o)
  );

endmodule
